// ===== rtl/rar_pkg.sv =====
// ---------------------------------------------------------------------------
// rar_pkg
// Types and constants shared by the rational arithmetic reduction core.
// ---------------------------------------------------------------------------
`default_nettype none

package rar_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIVZERO  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam int MAG_W     = 64;
  localparam int DIV_STEPS = 64;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] a_num;
    logic [30:0]        a_den;
    logic signed [31:0] b_num;
    logic [30:0]        b_den;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_num;
    logic [30:0]        result_den;
    logic [1:0]         status;
  } rsp_t;

  // One classified job between the front and the back.
  typedef struct packed {
    logic             divz;
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] dmag;
  } job_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_sts_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL0,
    F_MUL1,
    F_MUL2,
    F_COMB
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_GCD2,
    B_GCD,
    B_DIVN,
    B_DIVD,
    B_DONE
  } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/rar_front.sv =====
// ---------------------------------------------------------------------------
// rar_front
// Accepts a request, checks for division by zero and forms the numerator
// and denominator magnitudes with one shared multiplier in the states F_MUL0, F_MUL1 and F_MUL2.
// ---------------------------------------------------------------------------
`default_nettype none

module rar_front
  import rar_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req_data,
  input  wire logic q_full,
  output logic      q_push,
  output job_t      q_job
);

  front_state_t state, state_next;
  req_t r;
  logic divz;
  logic signed [63:0] p0, p1, p2;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [64:0] num_s;
  logic [MAG_W-1:0] num_mag, den_mag;
  logic accept, divz_in;

  assign accept  = req_valid && !req_stall;
  assign divz_in = (req_data.a_den == '0) || (req_data.b_den == '0) ||
                   ((req_data.kind == OP_DIV) && (req_data.b_num == '0));

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    q_push     = 1'b0;
    case (state)
      F_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) state_next = divz_in ? F_COMB : F_MUL0;
      end
      F_MUL0: state_next = F_MUL1;
      F_MUL1: state_next = F_MUL2;
      F_MUL2: state_next = F_COMB;
      F_COMB: begin
        if (!q_full) begin
          q_push     = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = {r.a_num[31], r.a_num};
    mul_b = $signed({2'b00, r.b_den});
    case (state)
      F_MUL0: begin
        if (r.kind == OP_MUL) mul_b = {r.b_num[31], r.b_num};
      end
      F_MUL1: begin
        mul_a = {r.b_num[31], r.b_num};
        mul_b = $signed({2'b00, r.a_den});
      end
      F_MUL2: begin
        mul_a = $signed({2'b00, r.a_den});
        if (r.kind == OP_DIV) mul_b = {r.b_num[31], r.b_num};
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (accept) begin
      r    <= req_data;
      divz <= divz_in;
    end
    case (state)
      F_MUL0:  p0 <= mul_p[63:0];
      F_MUL1:  p1 <= mul_p[63:0];
      F_MUL2:  p2 <= mul_p[63:0];
      default: ;
    endcase
  end

  always_comb begin
    case (r.kind)
      OP_ADD:  num_s = {p0[63], p0} + {p1[63], p1};
      OP_SUB:  num_s = {p0[63], p0} - {p1[63], p1};
      default: num_s = {p0[63], p0};
    endcase
    num_mag = num_s[64] ? MAG_W'(-num_s) : num_s[MAG_W-1:0];
    den_mag = p2[63] ? MAG_W'(-p2) : p2;
    q_job.divz = divz;
    q_job.neg  = num_s[64] ^ p2[63];
    q_job.mag  = num_mag;
    q_job.dmag = den_mag;
  end

endmodule

`default_nettype wire

// ===== rtl/rar_queue.sv =====
// ---------------------------------------------------------------------------
// rar_queue
// Two-entry queue of classified jobs between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module rar_queue
  import rar_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire q_ctl_t ctl,
  input  wire job_t   wr_job,
  output q_sts_t      sts,
  output job_t        rd_job
);

  job_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign sts.full  = (count == 2'd2);
  assign sts.empty = (count == 2'd0);
  assign do_push   = ctl.push && !sts.full;
  assign do_pop    = ctl.pop && !sts.empty;
  assign rd_job    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
    if (do_push) mem[wr_ptr] <= wr_job;
  end

endmodule

`default_nettype wire

// ===== rtl/rar_back.sv =====
// ---------------------------------------------------------------------------
// rar_back
// Reduces a job by a binary gcd, divides both magnitudes by it with one
// shared restoring divider and holds the result in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module rar_back
  import rar_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire job_t q_job,
  input  wire logic q_empty,
  output logic      q_pop,
  output logic      res_valid,
  input  wire logic res_stall,
  output rsp_t      res_data
);

  localparam logic [MAG_W-1:0] LIMIT = MAG_W'((64'd1 << (WIDTH - 1)) - 64'd1);

  back_state_t state, state_next;
  logic             neg, divz;
  logic [MAG_W-1:0] num_q, den_q, u, v, g, dq, rem;
  logic [5:0]       k, cnt;
  logic [MAG_W:0]   trial;
  logic [MAG_W-1:0] rem_next, dq_next;
  logic             load, last_step;

  assign load      = (state == B_DONE) && (!res_valid || !res_stall);
  assign q_pop     = (state == B_IDLE) && !q_empty;
  assign last_step = (cnt == 6'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          state_next = (q_job.divz || (q_job.mag == '0)) ? B_DONE : B_GCD2;
        end
      end
      B_GCD2:  if (u[0] || v[0]) state_next = B_GCD;
      B_GCD:   if (u == '0) state_next = B_DIVN;
      B_DIVN:  if (last_step) state_next = B_DIVD;
      B_DIVD:  if (last_step) state_next = B_DONE;
      B_DONE:  if (load) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // One restoring division step.
  always_comb begin
    trial = {rem, dq[MAG_W-1]} - {1'b0, g};
    if (!trial[MAG_W]) begin
      rem_next = trial[MAG_W-1:0];
      dq_next  = {dq[MAG_W-2:0], 1'b1};
    end else begin
      rem_next = {rem[MAG_W-2:0], dq[MAG_W-1]};
      dq_next  = {dq[MAG_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (q_pop) begin
          neg   <= q_job.neg;
          divz  <= q_job.divz;
          num_q <= q_job.mag;
          den_q <= q_job.dmag;
          u     <= q_job.mag;
          v     <= q_job.dmag;
          k     <= '0;
        end
      end
      B_GCD2: begin
        if (!u[0] && !v[0]) begin
          u <= u >> 1;
          v <= v >> 1;
          k <= k + 6'd1;
        end
      end
      B_GCD: begin
        if (u == '0) begin
          g   <= v << k;
          dq  <= num_q;
          rem <= '0;
          cnt <= '0;
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (u >= v) begin
          u <= u - v;
        end else begin
          v <= v - u;
        end
      end
      B_DIVN: begin
        cnt <= cnt + 6'd1;
        if (last_step) begin
          num_q <= dq_next;
          dq    <= den_q;
          rem   <= '0;
        end else begin
          dq  <= dq_next;
          rem <= rem_next;
        end
      end
      B_DIVD: begin
        cnt <= cnt + 6'd1;
        dq  <= dq_next;
        rem <= rem_next;
        if (last_step) den_q <= dq_next;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (load) begin
      if (divz) begin
        res_data <= '{result_num: '0, result_den: 31'd1, status: ST_DIVZERO};
      end else if (num_q == '0) begin
        res_data <= '{result_num: '0, result_den: 31'd1, status: ST_OK};
      end else if ((num_q > LIMIT) || (den_q > LIMIT)) begin
        res_data <= '{result_num: '0, result_den: 31'd1, status: ST_OVERFLOW};
      end else begin
        res_data.result_num <= neg ? -$signed(num_q[31:0]) : $signed(num_q[31:0]);
        res_data.result_den <= den_q[30:0];
        res_data.status     <= ST_OK;
      end
    end
  end

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIVN) |-> (g != '0))
    else $error("gcd is zero during division");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state != B_IDLE))
    else $error("job popped but back stayed idle");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_data.status == ST_OK)) |-> (res_data.result_den != '0))
    else $error("valid result with zero denominator");

  a_load_only_done: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(res_valid)) |-> ($past(state) == B_DONE))
    else $error("result loaded outside the done state");
`endif

endmodule

`default_nettype wire

// ===== rtl/rational_arithmetic_reduce_core.sv =====
// ---------------------------------------------------------------------------
// rational_arithmetic_reduce_core
// Rational add, subtract, multiply and divide with gcd reduction.
// ---------------------------------------------------------------------------
// A request on req_data is taken when req_valid is high and req_stall low.
// The front forms the cross-products, one after another, with one shared
// multiplier and hands the job to a two-entry queue, so it can take the
// next request while the back is still busy.
// The back finds the gcd with a binary gcd loop (one subtract or shift
// per cycle) and divides numerator and denominator by it, one after the
// other, in one shared restoring divider. A division by zero and a zero
// numerator skip the gcd and the divider. The gcd loop and the divider
// set the sustained rate of one result per back pass.
// Results appear on res_data with res_valid and stay held while res_stall
// is high; the front keeps working until the queue is full.
// Reset clears the handshake state and empties the queue; the block keeps
// no other state between requests.
// ---------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_reduce_core
  import rar_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req_data,
  output logic      res_valid,
  input  wire logic res_stall,
  output rsp_t      res_data
);

  q_ctl_t q_ctl;
  q_sts_t q_sts;
  job_t   wr_job, rd_job;

  rar_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .q_full    (q_sts.full),
    .q_push    (q_ctl.push),
    .q_job     (wr_job)
  );

  rar_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .ctl    (q_ctl),
    .wr_job (wr_job),
    .sts    (q_sts),
    .rd_job (rd_job)
  );

  rar_back #(
    .WIDTH (WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_job     (rd_job),
    .q_empty   (q_sts.empty),
    .q_pop     (q_ctl.pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

`default_nettype wire
